>>> rtl/gamepad_poll_sequencer_top_macros.svh
// Assertion macros for the gamepad poll sequencer.
// Expects clk and rst_n in the scope of each use.
`ifndef GAMEPAD_POLL_SEQUENCER_TOP_MACROS_SVH
`define GAMEPAD_POLL_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gamepad poll sequencer: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define GPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gamepad poll sequencer: next-cycle check failed");

`endif

>>> rtl/gps_pkg.sv
// Shared types, codes and the command table of the gamepad poll sequencer.
// No dependencies.
package gps_pkg;

    localparam int STEP_COUNT = 6;
    localparam int POS_W      = 5;
    localparam int STEP_W     = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = 3'(STEP_COUNT - 1);
    localparam logic [7:0] ABSENT_BYTE = 8'hff;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_BYTE = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_BUTTON  = 2'd2,
        KIND_IGNORED = 2'd3
    } kind_t;

    // Control from the sequencer to the button store
    typedef struct packed {
        logic clear;
        logic load;
    } store_ctrl_t;

    // Bytes in each step's command frame
    function automatic logic [POS_W-1:0] step_length(input logic [STEP_W-1:0] s);
        logic [POS_W-1:0] n;
        case (s)
            3'd0:    n = 5'd5;
            3'd1:    n = 5'd5;
            3'd2:    n = 5'd9;
            3'd3:    n = 5'd9;
            3'd4:    n = 5'd9;
            3'd5:    n = 5'd21;
            default: n = 5'd5;
        endcase
        return n;
    endfunction

    // Command byte sent at a position of a step's frame
    function automatic logic [7:0] step_byte(input logic [STEP_W-1:0] s,
                                             input logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        if (pos == 5'd0) begin
            b = 8'h01;
        end
        else begin
            case (s)
                3'd0:
                begin
                    if (pos == 5'd1) b = 8'h42;
                end
                3'd1:
                begin
                    if (pos == 5'd1) b = 8'h43;
                    if (pos == 5'd3) b = 8'h01;
                end
                3'd2:
                begin
                    if (pos == 5'd1) b = 8'h44;
                    if (pos == 5'd3) b = 8'h01;
                    if (pos == 5'd4) b = 8'h03;
                end
                3'd3:
                begin
                    if (pos == 5'd1) b = 8'h4f;
                    if (pos == 5'd3 || pos == 5'd4) b = 8'hff;
                    if (pos == 5'd5) b = 8'h03;
                end
                3'd4:
                begin
                    if (pos == 5'd1) b = 8'h43;
                    if (pos >= 5'd4 && pos <= 5'd8) b = 8'h5a;
                end
                3'd5:
                begin
                    if (pos == 5'd1) b = 8'h42;
                end
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    // Button byte with no controller attached: sticks centered, no keys
    function automatic logic [7:0] idle_byte(input int k);
        logic [7:0] b;
        if (k < 2) b = 8'hff;
        else if (k < 6) b = 8'h7f;
        else b = 8'h00;
        return b;
    endfunction

endpackage

>>> rtl/gamepad_poll_sequencer_top.sv
// Gamepad poll sequencer: one result word for every input word.
// The result is registered and valid in the cycle after input accept; throughput 1 word per
// cycle while m_tready stays high, set by the single register stage that holds the result
// (ready passes through when the result register is empty or being taken).
// Reset (rst_n, async, active low): step 0, idle, attention high, controller absent,
// button store at the idle pattern. No clearing pass.
module gamepad_poll_sequencer_top #(
    parameter int BUTTON_BYTES    = 18,
    parameter int MAX_FRAME_BYTES = 21
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] value, [8] attention, [11:9] sequence_step,
                                   // [12] present, [15:13] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);

    localparam int FB_AW  = $clog2(MAX_FRAME_BYTES);
    localparam int IDX_W  = $clog2(BUTTON_BYTES);
    localparam logic [gps_pkg::POS_W-1:0] MAX_LEN = gps_pkg::POS_W'(MAX_FRAME_BYTES);

    // Sequencer state
    logic [gps_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic [gps_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       present_reg, present_next;

    // Result register
    logic                       out_valid_reg;
    gps_pkg::kind_t             out_kind_reg, kind_next;
    logic [7:0]                 out_value_reg, value_next;
    logic                       out_att_reg;
    logic [gps_pkg::STEP_W-1:0] out_step_reg;
    logic                       out_present_reg;

    logic                       accept;
    gps_pkg::cmd_t              cmd;
    logic [gps_pkg::POS_W-1:0]  pos_inc;
    logic [gps_pkg::POS_W-1:0]  step_len;
    logic [gps_pkg::POS_W-1:0]  frame_len;
    logic                       fb_we;
    logic [7:0]                 fb_view [MAX_FRAME_BYTES];
    gps_pkg::store_ctrl_t       store_ctrl;
    logic                       read_ok;
    logic [7:0]                 rd_data;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = gps_pkg::cmd_t'(s_tuser);
    assign pos_inc  = pos_reg + 5'd1;
    assign step_len = gps_pkg::step_length(step_reg);
    assign frame_len = (step_len < MAX_LEN) ? step_len : MAX_LEN;
    assign read_ok  = s_tdata < 8'(BUTTON_BYTES);

    gps_frame_buffer #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_frame (
        .clk     (clk),
        .wr_en   (fb_we),
        .wr_addr (pos_reg[FB_AW-1:0]),
        .wr_data (s_tdata),
        .view    (fb_view)
    );

    gps_button_store #(
        .BUTTON_BYTES   (BUTTON_BYTES),
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (store_ctrl),
        .frame   (fb_view),
        .rd_idx  (s_tdata[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Decode the accepted word and advance the frame sequence
    always_comb
    begin
        step_next    = step_reg;
        busy_next    = busy_reg;
        pos_next     = pos_reg;
        present_next = present_reg;
        kind_next    = gps_pkg::KIND_IGNORED;
        value_next   = 8'h00;
        fb_we        = 1'b0;
        store_ctrl   = '0;
        if (accept) begin
            case (cmd)
                gps_pkg::CMD_TICK:
                begin
                    if (!busy_reg) begin
                        busy_next  = 1'b1;
                        pos_next   = '0;
                        kind_next  = gps_pkg::KIND_SEND;
                        value_next = gps_pkg::step_byte(step_reg, '0);
                    end
                end
                gps_pkg::CMD_BYTE:
                begin
                    if (busy_reg) begin
                        fb_we = 1'b1;
                        if (pos_inc < frame_len) begin
                            pos_next   = pos_inc;
                            kind_next  = gps_pkg::KIND_SEND;
                            value_next = gps_pkg::step_byte(step_reg, pos_inc);
                        end
                        else begin
                            // Close the frame; byte 1 all ones means no controller
                            kind_next = gps_pkg::KIND_DONE;
                            busy_next = 1'b0;
                            pos_next  = '0;
                            if (fb_view[1] == gps_pkg::ABSENT_BYTE) begin
                                present_next     = 1'b0;
                                store_ctrl.clear = (step_reg == gps_pkg::LAST_STEP);
                                step_next        = '0;
                            end
                            else begin
                                present_next = 1'b1;
                                if (step_reg == gps_pkg::LAST_STEP) begin
                                    store_ctrl.load = 1'b1;
                                end
                                else begin
                                    step_next = step_reg + 3'd1;
                                end
                            end
                        end
                    end
                end
                gps_pkg::CMD_READ:
                begin
                    if (read_ok) begin
                        kind_next  = gps_pkg::KIND_BUTTON;
                        value_next = rd_data;
                    end
                end
                default:
                begin
                    kind_next = gps_pkg::KIND_IGNORED;
                end
            endcase
        end
    end

    // Hold state and the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg        <= '0;
            busy_reg        <= 1'b0;
            pos_reg         <= '0;
            present_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= gps_pkg::KIND_IGNORED;
            out_value_reg   <= 8'h00;
            out_att_reg     <= 1'b1;
            out_step_reg    <= '0;
            out_present_reg <= 1'b0;
        end
        else begin
            step_reg    <= step_next;
            busy_reg    <= busy_next;
            pos_reg     <= pos_next;
            present_reg <= present_next;
            if (accept) begin
                out_valid_reg   <= 1'b1;
                out_kind_reg    <= kind_next;
                out_value_reg   <= value_next;
                out_att_reg     <= !busy_next;
                out_step_reg    <= step_next;
                out_present_reg <= present_next;
            end
            else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'b000, out_present_reg, out_step_reg, out_att_reg, out_value_reg};

`include "gamepad_poll_sequencer_top_macros.svh"

    `GPS_ASSERT_IMPL(a_step_range, 1'b1, step_reg <= gps_pkg::LAST_STEP)
    `GPS_ASSERT_IMPL(a_pos_in_frame, busy_reg, pos_reg < frame_len)
    `GPS_ASSERT_IMPL(a_done_raises_att, m_tvalid && m_tuser == gps_pkg::KIND_DONE, m_tdata[8])
    `GPS_ASSERT_NEXT(a_idle_byte_ignored, accept && cmd == gps_pkg::CMD_BYTE && !busy_reg,
                     m_tvalid && m_tuser == gps_pkg::KIND_IGNORED)

endmodule

>>> rtl/gps_frame_buffer.sv
// Receive buffer for one frame, with the byte being written passed through.
// Depends on nothing but its parameter.
module gps_frame_buffer #(
    parameter int MAX_FRAME_BYTES = 21
) (
    input  logic       clk,
    input  logic       wr_en,
    input  logic [$clog2(MAX_FRAME_BYTES)-1:0] wr_addr,
    input  logic [7:0] wr_data,
    output logic [7:0] view [MAX_FRAME_BYTES]
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    logic [7:0] mem_reg [MAX_FRAME_BYTES];

    // Store the received byte
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Show the frame as it stands after this word
    always_comb
    begin
        for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
            view[i] = (wr_en && wr_addr == AW'(i)) ? wr_data : mem_reg[i];
        end
    end

endmodule

>>> rtl/gps_button_store.sv
// Button store: loaded from a finished poll frame, cleared to idle, read by index.
// Depends on gps_pkg.
module gps_button_store #(
    parameter int BUTTON_BYTES    = 18,
    parameter int MAX_FRAME_BYTES = 21
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gps_pkg::store_ctrl_t      ctrl,
    input  logic [7:0]                frame [MAX_FRAME_BYTES],
    input  logic [$clog2(BUTTON_BYTES)-1:0] rd_idx,
    output logic [7:0]                rd_data
);

    logic [7:0] store_reg  [BUTTON_BYTES];
    logic [7:0] store_next [BUTTON_BYTES];

    // Pick the next contents: frame bytes 3 and up on load, idle pattern on clear
    always_comb
    begin
        for (int k = 0; k < BUTTON_BYTES; k++) begin
            store_next[k] = store_reg[k];
            if (ctrl.clear) begin
                store_next[k] = gps_pkg::idle_byte(k);
            end
            else if (ctrl.load) begin
                store_next[k] = (k + 3 < MAX_FRAME_BYTES) ? frame[k + 3] : 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < BUTTON_BYTES; k++) begin
                store_reg[k] <= gps_pkg::idle_byte(k);
            end
        end
        else begin
            for (int k = 0; k < BUTTON_BYTES; k++) begin
                store_reg[k] <= store_next[k];
            end
        end
    end

    // Read one byte; an index past the end reads zero
    assign rd_data = (32'(rd_idx) < BUTTON_BYTES) ? store_reg[rd_idx] : 8'h00;

endmodule

>>> sim/tb_gamepad_poll_sequencer_top.sv
`timescale 1ns / 100ps
// Testbench for gamepad_poll_sequencer_top: a directed table, then random poll traffic.
// Every result word is checked against the table's expected word or an in-bench model of the poll sequencer.
// Depends on gps_pkg and the RTL top module only.
module tb_gamepad_poll_sequencer_top;

    localparam int BUTTON_BYTES     = 18;
    localparam int MAX_FRAME_BYTES  = 21;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int TARGET_WORDS     = 1350;
    localparam int QUIET_LIMIT      = 2000;
    localparam int HOLD_CYCLES      = 200;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct packed {
        gps_pkg::kind_t kind;
        logic [7:0]     value;
        logic           attention;
        logic [2:0]     step;
        logic           present;
    } result_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       known;
        result_t    want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    gamepad_poll_sequencer_top #(
        .BUTTON_BYTES    (BUTTON_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Model of the sequencer: command table, frame state, button store
    logic [7:0] cmd_bytes [0:gps_pkg::STEP_COUNT-1][0:MAX_FRAME_BYTES-1];
    int         cmd_len   [0:gps_pkg::STEP_COUNT-1];
    logic [2:0] seq_step;
    logic       seq_busy;
    logic [4:0] seq_pos;
    logic [7:0] rx_frame  [0:MAX_FRAME_BYTES-1];
    logic [7:0] pad_store [0:BUTTON_BYTES-1];
    logic       pad_present;

    result_t   pending_results [$];
    stim_row_t dir_rows [$];
    result_t   seen;
    result_t   oldest;

    int errors        = 0;
    int quiet_cycles  = 0;
    int n_words       = 0;
    int frames_closed = 0;
    int frames_absent = 0;
    int store_loads   = 0;
    int store_clears  = 0;
    int button_reads  = 0;
    bit no_idle       = 1'b0;
    bit flood         = 1'b0;
    bit rx_hold_req   = 1'b0;

    // Sticks centered, no keys pressed
    function automatic void reset_buttons();
        int k;
        for (k = 0; k < BUTTON_BYTES; k++)
        begin
            pad_store[k] = (k < 2) ? 8'hff : (k < 6) ? 8'h7f : 8'h00;
        end
    endfunction

    // Advance the model by one input word and return the result word it causes
    function automatic result_t next_poll_result(input logic [1:0] cmd, input logic [7:0] data);
        result_t r;
        int k;
        r.kind  = gps_pkg::KIND_IGNORED;
        r.value = 8'h00;
        case (cmd)
            gps_pkg::CMD_TICK:
            begin
                if (!seq_busy)
                begin
                    seq_busy = 1'b1;
                    seq_pos  = 5'd0;
                    r.kind   = gps_pkg::KIND_SEND;
                    r.value  = cmd_bytes[seq_step][0];
                end
            end
            gps_pkg::CMD_BYTE:
            begin
                if (seq_busy)
                begin
                    rx_frame[seq_pos] = data;
                    if (seq_pos + 1 < cmd_len[seq_step])
                    begin
                        seq_pos = seq_pos + 5'd1;
                        r.kind  = gps_pkg::KIND_SEND;
                        r.value = cmd_bytes[seq_step][seq_pos];
                    end
                    else
                    begin
                        // Close the frame: restart on a missing pad, else advance or load
                        frames_closed++;
                        if (rx_frame[1] == gps_pkg::ABSENT_BYTE)
                        begin
                            pad_present = 1'b0;
                            frames_absent++;
                            if (seq_step == gps_pkg::LAST_STEP)
                            begin
                                reset_buttons();
                                store_clears++;
                            end
                            seq_step = 3'd0;
                        end
                        else
                        begin
                            pad_present = 1'b1;
                            if (seq_step == gps_pkg::LAST_STEP)
                            begin
                                for (k = 0; k < BUTTON_BYTES; k++)
                                begin
                                    pad_store[k] = (k + 3 < MAX_FRAME_BYTES) ? rx_frame[k + 3]
                                                                             : 8'h00;
                                end
                                store_loads++;
                            end
                            else
                            begin
                                seq_step = seq_step + 3'd1;
                            end
                        end
                        seq_busy = 1'b0;
                        seq_pos  = 5'd0;
                        r.kind   = gps_pkg::KIND_DONE;
                    end
                end
            end
            gps_pkg::CMD_READ:
            begin
                if (data < BUTTON_BYTES)
                begin
                    r.kind  = gps_pkg::KIND_BUTTON;
                    r.value = pad_store[data[4:0]];
                    button_reads++;
                end
            end
            default:
            begin
            end
        endcase
        r.attention = !seq_busy;
        r.step      = seq_step;
        r.present   = pad_present;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(40, 20);
    endfunction

    // Button index, now and then out of range
    function automatic logic [7:0] read_index();
        if ($urandom_range(6) == 0)
            return 8'($urandom_range(255, BUTTON_BYTES));
        return 8'($urandom_range(BUTTON_BYTES - 1));
    endfunction

    // Choose the next word: well-formed frames with random content, plus noise
    function automatic void pick_word(output logic [1:0] cmd, output logic [7:0] data);
        int r;
        r    = $urandom_range(99);
        data = 8'($urandom_range(255));
        if (seq_busy)
        begin
            if (r < 86)
            begin
                cmd = gps_pkg::CMD_BYTE;
                if (seq_pos == 5'd1 && $urandom_range(11) == 0)
                    data = gps_pkg::ABSENT_BYTE;
            end
            else if (r < 90)
                cmd = gps_pkg::CMD_TICK;
            else if (r < 97)
            begin
                cmd  = gps_pkg::CMD_READ;
                data = read_index();
            end
            else
                cmd = CMD_SPARE;
        end
        else
        begin
            if (r < 60)
                cmd = gps_pkg::CMD_TICK;
            else if (r < 85)
            begin
                cmd  = gps_pkg::CMD_READ;
                data = read_index();
            end
            else if (r < 93)
                cmd = gps_pkg::CMD_BYTE;
            else
                cmd = CMD_SPARE;
        end
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [7:0] data);
        stim_row_t row;
        row       = '0;
        row.cmd   = cmd;
        row.data  = data;
        row.known = 1'b0;
        dir_rows.push_back(row);
    endtask

    task automatic add_known_row(input logic [1:0] cmd, input logic [7:0] data,
                                 input gps_pkg::kind_t kind,
                                 input logic [7:0] value, input logic att,
                                 input logic [2:0] step, input logic pres);
        stim_row_t row;
        row.cmd            = cmd;
        row.data           = data;
        row.known          = 1'b1;
        row.want.kind      = kind;
        row.want.value     = value;
        row.want.attention = att;
        row.want.step      = step;
        row.want.present   = pres;
        dir_rows.push_back(row);
    endtask

    // Offer one word after a random gap, hold it until accepted, then predict
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] data, output result_t res);
        int gap;
        gap = (no_idle || flood) ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        res = next_poll_result(cmd, data);
        n_words++;
    endtask

    // Stimulus
    initial
    begin
        stim_row_t  row;
        result_t    res;
        logic [1:0] cmd;
        logic [7:0] data;
        bit         hold_done;
        bit         pause_done;
        int         s;
        int         p;

        for (s = 0; s < gps_pkg::STEP_COUNT; s++)
        begin
            for (p = 0; p < MAX_FRAME_BYTES; p++)
                cmd_bytes[s][p] = 8'h00;
            cmd_bytes[s][0] = 8'h01;
        end
        cmd_bytes[0][1] = 8'h42;
        cmd_bytes[1][1] = 8'h43;
        cmd_bytes[1][3] = 8'h01;
        cmd_bytes[2][1] = 8'h44;
        cmd_bytes[2][3] = 8'h01;
        cmd_bytes[2][4] = 8'h03;
        cmd_bytes[3][1] = 8'h4f;
        cmd_bytes[3][3] = 8'hff;
        cmd_bytes[3][4] = 8'hff;
        cmd_bytes[3][5] = 8'h03;
        cmd_bytes[4][1] = 8'h43;
        for (p = 4; p <= 8; p++)
            cmd_bytes[4][p] = 8'h5a;
        cmd_bytes[5][1] = 8'h42;
        cmd_len[0] = 5;
        cmd_len[1] = 5;
        cmd_len[2] = 9;
        cmd_len[3] = 9;
        cmd_len[4] = 9;
        cmd_len[5] = 21;
        seq_step    = 3'd0;
        seq_busy    = 1'b0;
        seq_pos     = 5'd0;
        pad_present = 1'b0;
        reset_buttons();
        hold_done  = 1'b0;
        pause_done = 1'b0;

        // Idle pattern reads, range edges, ignored words
        add_known_row(gps_pkg::CMD_READ, 8'd0,  gps_pkg::KIND_BUTTON,  8'hff, 1'b1, 3'd0, 1'b0);
        add_known_row(gps_pkg::CMD_READ, 8'd5,  gps_pkg::KIND_BUTTON,  8'h7f, 1'b1, 3'd0, 1'b0);
        add_known_row(gps_pkg::CMD_READ, 8'd17, gps_pkg::KIND_BUTTON,  8'h00, 1'b1, 3'd0, 1'b0);
        add_known_row(gps_pkg::CMD_READ, 8'd18, gps_pkg::KIND_IGNORED, 8'h00, 1'b1, 3'd0, 1'b0);
        add_known_row(gps_pkg::CMD_READ, 8'hff, gps_pkg::KIND_IGNORED, 8'h00, 1'b1, 3'd0, 1'b0);
        add_known_row(CMD_SPARE,         8'haa, gps_pkg::KIND_IGNORED, 8'h00, 1'b1, 3'd0, 1'b0);
        add_known_row(gps_pkg::CMD_BYTE, 8'h55, gps_pkg::KIND_IGNORED, 8'h00, 1'b1, 3'd0, 1'b0);
        // Probe frame with no controller, a tick and a read while busy
        add_known_row(gps_pkg::CMD_TICK, 8'h00, gps_pkg::KIND_SEND,    8'h01, 1'b0, 3'd0, 1'b0);
        add_known_row(gps_pkg::CMD_TICK, 8'hff, gps_pkg::KIND_IGNORED, 8'h00, 1'b0, 3'd0, 1'b0);
        add_known_row(gps_pkg::CMD_BYTE, 8'hff, gps_pkg::KIND_SEND,    8'h42, 1'b0, 3'd0, 1'b0);
        add_known_row(gps_pkg::CMD_BYTE, 8'hff, gps_pkg::KIND_SEND,    8'h00, 1'b0, 3'd0, 1'b0);
        add_known_row(gps_pkg::CMD_READ, 8'd3,  gps_pkg::KIND_BUTTON,  8'h7f, 1'b0, 3'd0, 1'b0);
        add_row(gps_pkg::CMD_BYTE, 8'h00);
        add_row(gps_pkg::CMD_BYTE, 8'h00);
        add_known_row(gps_pkg::CMD_BYTE, 8'h00, gps_pkg::KIND_DONE,    8'h00, 1'b1, 3'd0, 1'b0);
        // Probe frame with a controller present: advance to step 1
        add_row(gps_pkg::CMD_TICK, 8'h00);
        add_row(gps_pkg::CMD_BYTE, 8'h00);
        add_row(gps_pkg::CMD_BYTE, 8'h5a);
        add_row(gps_pkg::CMD_BYTE, 8'hff);
        add_row(gps_pkg::CMD_BYTE, 8'h00);
        add_row(gps_pkg::CMD_BYTE, 8'h81);
        add_known_row(CMD_SPARE,         8'hff, gps_pkg::KIND_IGNORED, 8'h00, 1'b1, 3'd1, 1'b1);
        add_row(gps_pkg::CMD_TICK, 8'h7e);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (s = 0; s < dir_rows.size(); s++)
        begin
            row = dir_rows[s];
            send_word(row.cmd, row.data, res);
            pending_results.push_back(row.known ? row.want : res);
        end

        while (n_words < TARGET_WORDS)
        begin
            // Long receiver hold while the sender floods the input
            if (!hold_done && n_words >= 300)
            begin
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
            end
            flood   = (n_words >= 300 && n_words < 380);
            no_idle = (n_words >= 900 && n_words < 1050);
            // Let the block drain completely once
            if (!pause_done && n_words >= 700)
            begin
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge clk);
            end
            pick_word(cmd, data);
            send_word(cmd, data, res);
            pending_results.push_back(res);
        end
        s_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d words: %0d frames closed, %0d of them with no controller,",
                 n_words, frames_closed, frames_absent);
        $display("%0d button-store loads, %0d clears, %0d button reads served.",
                 store_loads, store_clears, button_reads);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, one long hold on request
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                n = no_idle ? 0 : idle_len();
                if (n == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (n - 1) @(posedge clk);
                end
            end
        end
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_tvalid && m_tready)
            begin
                seen.kind      = gps_pkg::kind_t'(m_tuser);
                seen.value     = m_tdata[7:0];
                seen.attention = m_tdata[8];
                seen.step      = m_tdata[11:9];
                seen.present   = m_tdata[12];
                if (m_tdata[15:13] != 3'd0)
                begin
                    errors++;
                    $error("pad: expected 0, got %0d", m_tdata[15:13]);
                end
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $error("result word with nothing expected: kind %0d value %02h",
                           seen.kind, seen.value);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (seen.kind != oldest.kind)
                    begin
                        errors++;
                        $error("kind: expected %0d, got %0d", oldest.kind, seen.kind);
                    end
                    if (seen.value != oldest.value)
                    begin
                        errors++;
                        $error("value: expected %02h, got %02h", oldest.value, seen.value);
                    end
                    if (seen.attention != oldest.attention)
                    begin
                        errors++;
                        $error("attention: expected %0d, got %0d",
                               oldest.attention, seen.attention);
                    end
                    if (seen.step != oldest.step)
                    begin
                        errors++;
                        $error("sequence_step: expected %0d, got %0d", oldest.step, seen.step);
                    end
                    if (seen.present != oldest.present)
                    begin
                        errors++;
                        $error("present: expected %0d, got %0d", oldest.present, seen.present);
                    end
                end
            end
        end
    end

    // Watchdog: stop when no word has moved on either side for too long
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout: no word accepted for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
